[src/crt_pkg.sv]
// Shared types, widths and codes of the chunk reassembly tracker.
`timescale 1ns / 1ps
package crt_pkg;

    localparam int SIZE_W     = 22;
    localparam int OFFS_W     = 21;
    localparam int LEN_W      = 16;
    localparam int TICK_W     = 32;
    localparam int PCT_W      = 7;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int CHUNK_BYTES_DEF    = 1024;
    localparam int MAX_FILE_BYTES_DEF = 2097152;
    localparam int MAX_CHUNKS_DEF     = 2048;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef enum logic [CODE_W-1:0] {
        REJ_OK       = 3'd0,
        REJ_INACTIVE = 3'd1,
        REJ_BAD_LEN  = 3'd2,
        REJ_RANGE    = 3'd3,
        REJ_MISALIGN = 3'd4,
        REJ_SIZE     = 3'd5,
        REJ_DUP      = 3'd6
    } t_reject;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_SIZE = 2'd0,
        CFG_ENABLE     = 2'd1,
        CFG_TIMEOUT    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic item_ready;
        logic clear_step;
        logic check;
        logic calc;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic item_valid;
        logic restart;
        logic clear_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

[src/crt_if.sv]
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface crt_in_if
    import crt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [OFFS_W-1:0] chunk_start;
    logic [LEN_W-1:0]  chunk_length;

    modport source (output valid, mode, chunk_start, chunk_length, input ready);
    modport sink   (input valid, mode, chunk_start, chunk_length, output ready);
endinterface

interface crt_out_if
    import crt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [CODE_W-1:0] reject_code;
    logic [OFFS_W-1:0] write_address;
    logic              completed_now;
    logic              complete;
    logic [SIZE_W-1:0] received_bytes;
    logic [PCT_W-1:0]  progress_percent;
    logic              stalled;

    modport source (output valid, accepted, reject_code, write_address, completed_now,
                    complete, received_bytes, progress_percent, stalled, input ready);
    modport sink   (input valid, accepted, reject_code, write_address, completed_now,
                    complete, received_bytes, progress_percent, stalled, output ready);
endinterface

interface crt_cfg_if
    import crt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/crt_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module crt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/crt_ctrl.sv]
// Sequencer: map clearing pass, chunk lookup, check, percent divide, result hand-off.
`timescale 1ns / 1ps
module crt_ctrl
    import crt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.item_ready = 1'b1;
                if (i_status.item_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // a restart wipes the map again
        if (i_status.restart) begin
            n_state = ST_CLEAR;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == ST_CLEAR)
        else $error("controller not in clearing pass after reset");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.restart |=> r_state == ST_CLEAR)
        else $error("restart did not start a clearing pass");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN && !i_status.out_free && !i_status.restart |=> r_state == ST_FIN)
        else $error("result dropped while output register busy");

endmodule

[src/crt_dp.sv]
// Datapath: configuration, chunk checks, received map, counters, percent divider, result register.
`timescale 1ns / 1ps
module crt_dp
    import crt_pkg::*;
#(
    parameter int CHUNK_BYTES    = CHUNK_BYTES_DEF,
    parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
    parameter int MAX_CHUNKS     = MAX_CHUNKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    crt_in_if.sink     i_item,
    crt_out_if.source  o_result,
    crt_cfg_if.sink    i_cfg
);

    // CHUNK_BYTES is a power of two
    localparam int CHUNK_LOG2 = $clog2(CHUNK_BYTES);
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int EXT_W      = SIZE_W + 1;
    localparam int PROD_W     = SIZE_W + PCT_W;
    localparam int DSH_W      = SIZE_W + PCT_W - 1;
    localparam int DCNT_W     = $clog2(PCT_W);

    // configuration and tracking state
    logic [SIZE_W-1:0] r_total;
    logic              r_enable;
    logic [TICK_W-1:0] r_timeout;
    logic              r_valid_start;
    logic [CNT_W-1:0]  r_chunk_total;
    logic [SIZE_W-1:0] r_byte_count;
    logic              r_done;
    logic [TICK_W-1:0] r_idle;
    logic [IDX_W-1:0]  r_clr_cnt;

    // captured request and check results
    logic              r_mode;
    logic [OFFS_W-1:0] r_off;
    logic [LEN_W-1:0]  r_len;
    t_reject           r_code;
    logic              r_acc;
    logic              r_now;

    // percent divider
    logic [PROD_W-1:0] r_prod;
    logic [DSH_W-1:0]  r_dsh;
    logic [PCT_W-1:0]  r_q;
    logic              r_ge;
    logic [DCNT_W-1:0] r_div_cnt;

    // result register
    logic              r_out_valid;
    logic              r_o_acc;
    t_reject           r_o_code;
    logic [OFFS_W-1:0] r_o_addr;
    logic              r_o_now;
    logic              r_o_done;
    logic [SIZE_W-1:0] r_o_bytes;
    logic [PCT_W-1:0]  r_o_pct;
    logic              r_o_stalled;

    logic              take;
    logic              cfg_fire;
    logic              size_restart;
    logic [SIZE_W-1:0] cfg_total;
    logic [EXT_W-1:0]  cfg_chunks;
    logic              cfg_size_ok;
    logic              active;
    logic [OFFS_W-1:0] idx_full;
    logic [EXT_W-1:0]  idx_ext;
    logic              last_chunk;
    logic [EXT_W-1:0]  expect_len;
    logic              map_bit;
    t_reject           chk_code;
    logic              chunk_ok;
    logic [SIZE_W-1:0] byte_next;
    logic              clear_last;
    logic              div_sub;
    logic [PCT_W-1:0]  pct_now;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;

    assign take     = i_cmd.item_ready && i_item.valid;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign size_restart = cfg_fire && (i_cfg.index == CFG_TOTAL_SIZE) && r_enable;

    assign cfg_total   = i_cfg.data[SIZE_W-1:0];
    assign cfg_chunks  = (EXT_W'(cfg_total) + EXT_W'(CHUNK_BYTES - 1)) >> CHUNK_LOG2;
    assign cfg_size_ok = (cfg_total != '0)
                      && (32'(cfg_total) <= 32'(MAX_FILE_BYTES))
                      && (32'(cfg_chunks) <= 32'(MAX_CHUNKS));

    assign active     = r_enable && r_valid_start;
    assign idx_full   = r_off >> CHUNK_LOG2;
    assign idx_ext    = EXT_W'(idx_full);
    assign last_chunk = (idx_ext + EXT_W'(1)) == EXT_W'(r_chunk_total);
    assign expect_len = last_chunk ? (EXT_W'(r_total) - EXT_W'(r_off)) : EXT_W'(CHUNK_BYTES);

    // first failing check wins
    always_comb begin
        if (!active) begin
            chk_code = REJ_INACTIVE;
        end else if (r_len == '0 || (32'(r_len) > 32'(CHUNK_BYTES))) begin
            chk_code = REJ_BAD_LEN;
        end else if ((EXT_W'(r_off) + EXT_W'(r_len)) > EXT_W'(r_total)) begin
            chk_code = REJ_RANGE;
        end else if ((r_off & OFFS_W'(CHUNK_BYTES - 1)) != '0) begin
            chk_code = REJ_MISALIGN;
        end else if (idx_ext >= EXT_W'(r_chunk_total) || 32'(idx_ext) >= 32'(MAX_CHUNKS)) begin
            chk_code = REJ_RANGE;
        end else if (EXT_W'(r_len) != expect_len) begin
            chk_code = REJ_SIZE;
        end else if (map_bit) begin
            chk_code = REJ_DUP;
        end else begin
            chk_code = REJ_OK;
        end
    end

    assign chunk_ok   = !r_mode && (chk_code == REJ_OK);
    assign byte_next  = r_byte_count + SIZE_W'(r_len);
    assign clear_last = r_clr_cnt == IDX_W'(MAX_CHUNKS - 1);
    assign div_sub    = r_prod >= PROD_W'(r_dsh);
    assign pct_now    = r_ge ? PCT_FULL : r_q;

    // received map
    assign ram_we    = i_cmd.clear_step || (i_cmd.check && chunk_ok);
    assign ram_waddr = i_cmd.clear_step ? r_clr_cnt : idx_full[IDX_W-1:0];

    crt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CHUNKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (!i_cmd.clear_step),
        .i_raddr (idx_full[IDX_W-1:0]),
        .o_rdata (map_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total       <= '0;
            r_enable      <= 1'b0;
            r_timeout     <= '0;
            r_valid_start <= 1'b0;
            r_chunk_total <= '0;
            r_byte_count  <= '0;
            r_done        <= 1'b0;
            r_idle        <= '0;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // a restart begins a fresh clearing pass
            if (size_restart) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clear_step) begin
                r_clr_cnt <= clear_last ? '0 : r_clr_cnt + IDX_W'(1);
            end
            if (i_cmd.check) begin
                if (r_mode) begin
                    // saturate idle count
                    if (r_idle != '1) begin
                        r_idle <= r_idle + TICK_W'(1);
                    end
                end else if (chk_code == REJ_OK) begin
                    r_byte_count <= byte_next;
                    r_idle       <= '0;
                    if (byte_next == r_total) begin
                        r_done <= 1'b1;
                    end
                end
            end
            if (cfg_fire) begin
                unique case (i_cfg.index)
                    CFG_TOTAL_SIZE: begin
                        r_total <= cfg_total;
                        if (r_enable) begin
                            r_byte_count  <= '0;
                            r_idle        <= '0;
                            r_done        <= 1'b0;
                            r_valid_start <= cfg_size_ok;
                            r_chunk_total <= cfg_size_ok ? CNT_W'(cfg_chunks) : '0;
                        end else begin
                            r_valid_start <= 1'b0;
                        end
                    end
                    CFG_ENABLE: begin
                        r_enable <= i_cfg.data[0];
                        if (!i_cfg.data[0]) begin
                            r_done <= 1'b0;
                        end
                    end
                    CFG_TIMEOUT: begin
                        r_timeout <= i_cfg.data[TICK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_item.mode;
            r_off  <= i_item.chunk_start;
            r_len  <= i_item.chunk_length;
        end
        if (i_cmd.check) begin
            r_code <= r_mode ? REJ_OK : chk_code;
            r_acc  <= chunk_ok;
            r_now  <= chunk_ok && (byte_next == r_total);
        end
        if (i_cmd.calc) begin
            r_prod    <= PROD_W'(r_byte_count) * PROD_W'(PCT_FULL);
            r_dsh     <= {r_total, (PCT_W - 1)'(0)};
            r_ge      <= r_byte_count >= r_total;
            r_q       <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_sub) begin
                r_prod <= r_prod - PROD_W'(r_dsh);
            end
            r_q       <= {r_q[PCT_W-2:0], div_sub};
            r_dsh     <= r_dsh >> 1;
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_o_acc     <= r_acc;
            r_o_code    <= r_code;
            r_o_addr    <= r_acc ? r_off : '0;
            r_o_now     <= r_now;
            r_o_done    <= r_done;
            r_o_bytes   <= r_byte_count;
            r_o_pct     <= active ? pct_now : '0;
            r_o_stalled <= active && !r_done && (r_idle > r_timeout);
        end
    end

    assign o_status.item_valid = i_item.valid;
    assign o_status.restart    = size_restart;
    assign o_status.clear_last = clear_last;
    assign o_status.div_last   = r_div_cnt == DCNT_W'(PCT_W - 1);
    assign o_status.out_free   = !r_out_valid || o_result.ready;

    assign i_item.ready = i_cmd.item_ready;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid            = r_out_valid;
    assign o_result.accepted         = r_o_acc;
    assign o_result.reject_code      = r_o_code;
    assign o_result.write_address    = r_o_addr;
    assign o_result.completed_now    = r_o_now;
    assign o_result.complete         = r_o_done;
    assign o_result.received_bytes   = r_o_bytes;
    assign o_result.progress_percent = r_o_pct;
    assign o_result.stalled          = r_o_stalled;

    a_done_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_enable && (r_byte_count == r_total))
        else $error("complete flag set without all bytes or while disabled");

    a_stall_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_stalled |-> !r_o_done)
        else $error("stalled reported on a complete transfer");

    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_pct <= PCT_FULL)
        else $error("progress above full scale");

    a_now_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_now |-> r_o_done && r_o_acc)
        else $error("completion pulse without accepted chunk");

endmodule

[src/chunk_reassembly_tracker_top.sv]
// A request is accepted in the idle state; its result is loaded into the output register at the hand-off.
// No new request is taken until the last one has passed map lookup, check, multiply, the seven-step percent
// divider and the hand-off; a result still waiting holds the sequencer at the hand-off.
// The output register lets the next request enter while a result waits to be taken.
// Reset: synchronous, active low; a clearing pass sweeps every entry of the received map
// after reset and after each restart, with no request taken while it runs.
`timescale 1ns / 1ps
module chunk_reassembly_tracker_top
    import crt_pkg::*;
#(
    parameter int CHUNK_BYTES    = CHUNK_BYTES_DEF,
    parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF,
    parameter int MAX_CHUNKS     = MAX_CHUNKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crt_in_if.sink    i_item,
    crt_out_if.source o_result,
    crt_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;

    crt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    crt_dp #(
        .CHUNK_BYTES    (CHUNK_BYTES),
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .MAX_CHUNKS     (MAX_CHUNKS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

[tb/crt_reassembly_checker.sv]
// Watches the tracker channels, predicts each status result and compares it with the block.
`timescale 1ns / 1ps
module crt_reassembly_checker
    import crt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    crt_in_if    req_ch,
    crt_out_if   res_ch,
    crt_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic              accepted;
        t_reject           code;
        logic [OFFS_W-1:0] addr;
        logic              now_done;
        logic              done;
        logic [SIZE_W-1:0] bytes;
        logic [PCT_W-1:0]  pct;
        logic              stalled;
    } t_status_rec;

    // Tracker image: registers and transfer state
    logic [SIZE_W-1:0]         size_reg;
    logic                      enable_reg;
    logic [TICK_W-1:0]         timeout_reg;
    logic [MAX_CHUNKS_DEF-1:0] got_map;
    logic [SIZE_W-1:0]         byte_cnt;
    logic [11:0]               grid_chunks;
    logic                      done_r;
    logic [TICK_W-1:0]         idle_cnt;
    logic                      size_ok;

    t_status_rec awaited_status[$];
    int          mismatches = 0;

    function automatic void clear_tracker();
        size_reg    = '0;
        enable_reg  = 1'b0;
        timeout_reg = '0;
        got_map     = '0;
        byte_cnt    = '0;
        grid_chunks = '0;
        done_r      = 1'b0;
        idle_cnt    = '0;
        size_ok     = 1'b0;
    endfunction

    function automatic void restart_transfer();
        int unsigned n_chunks;
        n_chunks = (int'(size_reg) + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF;
        got_map  = '0;
        byte_cnt = '0;
        idle_cnt = '0;
        done_r   = 1'b0;
        if (size_reg == 0 || int'(size_reg) > MAX_FILE_BYTES_DEF ||
            n_chunks > MAX_CHUNKS_DEF) begin
            size_ok     = 1'b0;
            grid_chunks = '0;
        end else begin
            size_ok     = 1'b1;
            grid_chunks = n_chunks[11:0];
        end
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TOTAL_SIZE: begin
                size_reg = val[SIZE_W-1:0];
                if (enable_reg) restart_transfer();
                else size_ok = 1'b0;
            end
            CFG_ENABLE: begin
                enable_reg = val[0];
                // cancel drops the completion flag
                if (!val[0]) done_r = 1'b0;
            end
            CFG_TIMEOUT: timeout_reg = val;
            default: ;
        endcase
    endfunction

    function automatic t_reject chunk_verdict(logic [OFFS_W-1:0] off, logic [LEN_W-1:0] len);
        int unsigned off_u, len_u, size_u, idx, want;
        off_u  = 32'(off);
        len_u  = 32'(len);
        size_u = 32'(size_reg);
        if (!(enable_reg && size_ok)) return REJ_INACTIVE;
        if (len_u == 0 || len_u > CHUNK_BYTES_DEF) return REJ_BAD_LEN;
        if (off_u + len_u > size_u) return REJ_RANGE;
        if (off_u % CHUNK_BYTES_DEF != 0) return REJ_MISALIGN;
        idx = off_u / CHUNK_BYTES_DEF;
        if (idx >= grid_chunks || idx >= MAX_CHUNKS_DEF) return REJ_RANGE;
        want = (idx + 1 == grid_chunks) ? size_u - off_u : CHUNK_BYTES_DEF;
        if (len_u != want) return REJ_SIZE;
        if (got_map[idx]) return REJ_DUP;
        return REJ_OK;
    endfunction

    function automatic t_status_rec predict_status(logic mode, logic [OFFS_W-1:0] off,
                                                   logic [LEN_W-1:0] len);
        t_status_rec     r;
        longint unsigned p;
        r = '0;
        if (mode) begin
            // saturate the idle counter
            if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
        end else begin
            r.code = chunk_verdict(off, len);
            if (r.code == REJ_OK) begin
                got_map[int'(off) / CHUNK_BYTES_DEF] = 1'b1;
                byte_cnt   = byte_cnt + SIZE_W'(len);
                idle_cnt   = '0;
                r.accepted = 1'b1;
                r.addr     = off;
                if (byte_cnt == size_reg) begin
                    done_r     = 1'b1;
                    r.now_done = 1'b1;
                end
            end
        end
        if (enable_reg && size_ok && size_reg != 0) begin
            p         = 64'(byte_cnt) * 64'd100 / 64'(size_reg);
            r.pct     = (p > 100) ? PCT_FULL : p[PCT_W-1:0];
            r.stalled = !done_r && (idle_cnt > timeout_reg);
        end
        r.done  = done_r;
        r.bytes = byte_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_status_rec got;
        t_status_rec want;
        if (!i_rst_n) begin
            clear_tracker();
            awaited_status.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) apply_write(cfg_ch.index, cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                awaited_status.push_back(predict_status(req_ch.mode, req_ch.chunk_start,
                                                        req_ch.chunk_length));
            if (res_ch.valid && res_ch.ready) begin
                got.accepted = res_ch.accepted;
                got.code     = t_reject'(res_ch.reject_code);
                got.addr     = res_ch.write_address;
                got.now_done = res_ch.completed_now;
                got.done     = res_ch.complete;
                got.bytes    = res_ch.received_bytes;
                got.pct      = res_ch.progress_percent;
                got.stalled  = res_ch.stalled;
                if (awaited_status.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding", $realtime);
                end else begin
                    want = awaited_status.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: status mismatch exp acc=%0b code=%0d addr=%0h now=%0b done=%0b bytes=%0d pct=%0d stall=%0b",
                                     $realtime, want.accepted, want.code, want.addr,
                                     want.now_done, want.done, want.bytes, want.pct,
                                     want.stalled);
                            $display("%0t: status mismatch got acc=%0b code=%0d addr=%0h now=%0b done=%0b bytes=%0d pct=%0d stall=%0b",
                                     $realtime, got.accepted, got.code, got.addr,
                                     got.now_done, got.done, got.bytes, got.pct,
                                     got.stalled);
                        end
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= awaited_status.size();
    end

endmodule

[tb/chunk_reassembly_tracker_top_test.sv]
// Stimulus and verdict for the chunk reassembly tracker, checked by the reassembly checker.
`timescale 1ns / 1ps
module chunk_reassembly_tracker_top_test;
    import crt_pkg::*;

    localparam int                   ITEM_TARGET = 1800;
    localparam int                   CYCLE_LIMIT = 1500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;

    int unsigned file_size   = 0;
    int unsigned file_chunks = 0;
    int          sent        = 0;
    int          calm_left   = 0;

    crt_in_if  req_ch ();
    crt_out_if res_ch ();
    crt_cfg_if cfg_ch ();

    chunk_reassembly_tracker_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (req_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    crt_reassembly_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side: random stalls with occasional free-running stretches
    initial begin
        int stall_left;
        int free_left;
        stall_left   = 0;
        free_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                res_ch.ready = 1'b0;
                stall_left   = stall_left - 1;
            end else if (free_left != 0) begin
                res_ch.ready = 1'b1;
                free_left    = free_left - 1;
            end else begin
                res_ch.ready = 1'b1;
                if ($urandom_range(0, 19) == 0) free_left = $urandom_range(50, 300);
                else stall_left = pick_gap();
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    task automatic put_request(logic mode, logic [OFFS_W-1:0] off, logic [LEN_W-1:0] len);
        int gap;
        if (calm_left > 0) begin
            gap       = 0;
            calm_left = calm_left - 1;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(40, 120);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.mode         = mode;
        req_ch.chunk_start  = off;
        req_ch.chunk_length = len;
        do @(posedge i_clk); while (!req_ch.ready);
        sent = sent + 1;
    endtask

    task automatic put_chunk(int unsigned idx);
        int unsigned off;
        off = idx * CHUNK_BYTES_DEF;
        if (idx + 1 == file_chunks) put_request(1'b0, OFFS_W'(off), LEN_W'(file_size - off));
        else put_request(1'b0, OFFS_W'(off), LEN_W'(CHUNK_BYTES_DEF));
    endtask

    // Hold requests until every outstanding status has come back
    task automatic settle();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_file(int unsigned size);
        file_size = size;
        if (size == 0 || size > MAX_FILE_BYTES_DEF) file_chunks = 0;
        else file_chunks = (size + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF;
    endtask

    task automatic run_traffic(int count);
        int unsigned order[$];
        int unsigned k;
        int unsigned idx;
        int unsigned off;
        int unsigned len;
        int unsigned tmp;
        int unsigned j;
        int          r;
        for (int unsigned i = 0; i < file_chunks; i++) order.push_back(i);
        for (int unsigned i = order.size(); i > 1; i--) begin
            j            = $urandom_range(0, i - 1);
            tmp          = order[i-1];
            order[i-1]   = order[j];
            order[j]     = tmp;
        end
        k = 0;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 60 && k < order.size()) begin
                put_chunk(order[k]);
                k = k + 1;
            end else if (r < 75) begin
                put_request(1'b1, OFFS_W'($urandom), LEN_W'($urandom));
            end else if (r < 83 && k > 0) begin
                put_chunk(order[$urandom_range(0, k - 1)]);
            end else if (r < 93) begin
                // near-miss chunk: off-by-one length, skewed offset or past the end
                idx = (file_chunks == 0) ? 0 : $urandom_range(0, file_chunks - 1);
                off = idx * CHUNK_BYTES_DEF;
                len = (idx + 1 == file_chunks) ? file_size - off : CHUNK_BYTES_DEF;
                case ($urandom_range(0, 3))
                    0: len = len + 1;
                    1: len = len - 1;
                    2: off = off + $urandom_range(1, CHUNK_BYTES_DEF - 1);
                    default: begin
                        off = file_chunks * CHUNK_BYTES_DEF + $urandom_range(0, 4095);
                        len = CHUNK_BYTES_DEF;
                    end
                endcase
                put_request(1'b0, off[OFFS_W-1:0], len[LEN_W-1:0]);
            end else begin
                put_request(1'b0, OFFS_W'($urandom), LEN_W'($urandom));
            end
        end
    endtask

    initial begin
        int kind;
        int r;
        int unsigned size;
        logic [TICK_W-1:0] tmo;
        req_ch.valid        = 1'b0;
        req_ch.mode         = 1'b0;
        req_ch.chunk_start  = '0;
        req_ch.chunk_length = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_TOTAL_SIZE;
        cfg_ch.data         = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: inactive after reset
        put_request(1'b1, '0, '0);
        put_request(1'b0, '0, LEN_W'(CHUNK_BYTES_DEF));
        settle();
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_TIMEOUT, 32'd2);
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_TOTAL_SIZE, 32'd3000);
        // every reject reason other than inactive, short last chunk, duplicate, stall, completion
        put_request(1'b0, 21'd0, 16'd0);
        put_request(1'b0, 21'd0, 16'd1025);
        put_request(1'b0, '1, '1);
        put_request(1'b0, 21'd2048, 16'd1024);
        put_request(1'b0, 21'd5, 16'd100);
        put_request(1'b0, 21'd1024, 16'd500);
        put_request(1'b0, 21'd2048, 16'd952);
        put_request(1'b0, 21'd2048, 16'd952);
        repeat (3) put_request(1'b1, '0, '0);
        put_request(1'b0, 21'd0, 16'd1024);
        put_request(1'b0, 21'd1024, 16'd1024);
        put_request(1'b1, '0, '0);
        put_request(1'b0, '1, 16'd1);
        // cancel, then resume with the map kept
        settle();
        write_reg(CFG_ENABLE, 32'd0);
        put_request(1'b0, 21'd0, 16'd1024);
        settle();
        write_reg(CFG_ENABLE, 32'd1);
        put_request(1'b0, 21'd0, 16'd1024);
        put_request(1'b1, '0, '0);
        // sizes that leave the block inactive
        settle();
        write_reg(CFG_TIMEOUT, '1);
        write_reg(CFG_TOTAL_SIZE, 32'd0);
        put_request(1'b1, '0, '0);
        settle();
        write_reg(CFG_TOTAL_SIZE, 32'h003F_FFFF);
        put_request(1'b0, 21'd0, 16'd1024);
        settle();
        write_reg(CFG_ENABLE, 32'd0);
        write_reg(CFG_TOTAL_SIZE, MAX_FILE_BYTES_DEF);
        write_reg(CFG_ENABLE, 32'd1);
        put_request(1'b0, 21'd0, 16'd1024);
        // largest file, last chunk first
        settle();
        write_reg(CFG_TOTAL_SIZE, MAX_FILE_BYTES_DEF);
        write_reg(CFG_TIMEOUT, 32'd0);
        put_request(1'b0, OFFS_W'(MAX_FILE_BYTES_DEF - CHUNK_BYTES_DEF), 16'd1024);
        put_request(1'b1, '0, '0);

        // Random phases
        while (sent < ITEM_TARGET) begin
            settle();
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                r = $urandom_range(0, 19);
                if (r == 0) size = 0;
                else if (r == 1) size = $urandom_range(MAX_FILE_BYTES_DEF + 1, 22'h3F_FFFF);
                else if (r == 2) size = MAX_FILE_BYTES_DEF;
                else if (r < 7) size = CHUNK_BYTES_DEF * $urandom_range(1, 16);
                else size = $urandom_range(1, 16 * CHUNK_BYTES_DEF);
                set_file(size);
                r = $urandom_range(0, 9);
                if (r == 0) tmo = '0;
                else if (r == 1) tmo = '1;
                else if (r == 2) tmo = $urandom;
                else tmo = $urandom_range(1, 12);
                write_reg(CFG_TIMEOUT, tmo);
                if ($urandom_range(0, 7) == 0) begin
                    // size written while disabled stays inactive
                    write_reg(CFG_ENABLE, 32'd0);
                    write_reg(CFG_TOTAL_SIZE, size);
                    write_reg(CFG_ENABLE, 32'd1);
                end else begin
                    write_reg(CFG_ENABLE, 32'd1);
                    write_reg(CFG_TOTAL_SIZE, size);
                end
                if (file_chunks > 16 || file_chunks == 0) run_traffic($urandom_range(20, 40));
                else run_traffic($urandom_range(file_chunks + 5, 2 * file_chunks + 20));
            end else if (kind < 9) begin
                write_reg(CFG_ENABLE, 32'd0);
                run_traffic($urandom_range(3, 8));
                settle();
                write_reg(CFG_ENABLE, 32'd1);
                run_traffic($urandom_range(10, 30));
            end else begin
                write_reg(CFG_TIMEOUT, $urandom_range(0, 6));
                run_traffic($urandom_range(10, 30));
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
